@@ rtl/core/fsws_pkg.sv @@
// Shared types and constants for the flow sliding window statistics block.
`default_nettype none

package fsws_pkg;

   // Default sizes of the stamp ring and of each port set
   localparam int RING_DEPTH_DEFAULT     = 4096;
   localparam int PORT_SET_SLOTS_DEFAULT = 1024;

   // Arithmetic constants
   localparam logic [31:0] NANOS_PER_SECOND = 32'd1000000000;
   localparam logic [31:0] PORT_HASH_MUL    = 32'd2654435761;

   // Window register
   localparam int          WINDOW_W     = 12;
   localparam logic [11:0] WINDOW_RESET = 12'd10;

   // TCP flag bit positions in the flags byte
   localparam int FLAG_FIN = 0;
   localparam int FLAG_SYN = 1;
   localparam int FLAG_RST = 2;
   localparam int FLAG_PSH = 3;
   localparam int FLAG_ACK = 4;

   // Flag counter slots
   localparam int CNT_SYN = 0;
   localparam int CNT_ACK = 1;
   localparam int CNT_FIN = 2;
   localparam int CNT_RST = 3;
   localparam int CNT_PSH = 4;

   // Operations of the shared multiplier
   typedef enum logic [1:0] {
      MUL_SPAN,
      MUL_HASH,
      MUL_RECIP,
      MUL_QUOT
   } mul_op_type;

   typedef struct packed {
      mul_op_type  op;
      logic [31:0] operand;
   } mul_req_type;

endpackage

`default_nettype wire

@@ rtl/core/fsws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fsws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/fsws_mul.sv @@
// Shared 32 x 32 multiplier with registered product and per-operation constant factor.
`default_nettype none

module fsws_mul import fsws_pkg::*; #(
   parameter int PORT_SET_SLOTS = PORT_SET_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire mul_req_type req,
   output logic [63:0]      product
);

   // floor(2^32 / slots): quotient estimate is exact or one low
   localparam logic [31:0] SLOT_RECIP = 32'((64'd1 << 32) / PORT_SET_SLOTS);
   localparam logic [31:0] SLOT_COUNT = 32'(PORT_SET_SLOTS);

   logic [31:0] factor;
   logic [63:0] product_ff;

   // Pick the constant factor for the operation
   always_comb begin
      unique case (req.op)
         MUL_SPAN:  factor = NANOS_PER_SECOND;
         MUL_HASH:  factor = PORT_HASH_MUL;
         MUL_RECIP: factor = SLOT_RECIP;
         MUL_QUOT:  factor = SLOT_COUNT;
         default:   factor = '0;
      endcase
   end

   // Register the product
   always_ff @(posedge clock) begin
      product_ff <= 64'(req.operand) * 64'(factor);
   end

   assign product = product_ff;

endmodule

`default_nettype wire

@@ rtl/core/flow_sliding_window_stats.sv @@
// Top level: per-packet sliding window and flow counters with distinct port sets.
//
//   Channel   Direction  Signals                          Moves
//   req       in         req_tvalid/tready/tdata[119:0]   one packet request
//   rsp       out        rsp_tvalid/tready/tdata[295:0]   one statistics snapshot
//   csr       in         csr_wr_en, csr_wr_data[11:0]     window length in seconds
//
// A request steps through cut, evict (one ring entry dropped per step), push, and,
// for each port, hash, reciprocal, quotient, mod and probe (one occupied slot passed
// per step), then done. Eviction is skipped for an empty ring or a zero stamp, and a
// port of zero skips its hash-to-probe steps. The single shared multiplier forms the
// span, hash, reciprocal and quotient products. After reset both port sets are
// cleared, one slot a cycle; no request is taken meanwhile, register writes are.
// A finished snapshot waits in the output register; a new request may be taken
// while it waits, and the next result holds until the register is free.
`default_nettype none

module flow_sliding_window_stats import fsws_pkg::*; #(
   parameter int RING_DEPTH     = RING_DEPTH_DEFAULT,
   parameter int PORT_SET_SLOTS = PORT_SET_SLOTS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // req_tdata, low bit up: arrival_ns[63:0], payload_bytes[79:64], flag_bits[87:80],
   // source_port[103:88], destination_port[119:104]
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [119:0]  req_tdata,
   // rsp_tdata, low bit up: window_packets[12:0], packets_total[60:13],
   // bytes_total[108:61], syn_seen[140:109], ack_seen[172:141], fin_seen[204:173],
   // rst_seen[236:205], psh_seen[268:237], distinct_source_ports[279:269],
   // distinct_destination_ports[290:280], source_port_new[291],
   // destination_port_new[292], zero[295:293]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [295:0]       rsp_tdata,
   input  wire logic          csr_wr_en,
   input  wire logic [11:0]   csr_wr_data
);

   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int SLOT_W = $clog2(PORT_SET_SLOTS);

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(PORT_SET_SLOTS - 1);
   localparam logic [31:0]       SLOT_COUNT = 32'(PORT_SET_SLOTS);

   // Sequencer states
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_CUT   = 4'd2;
   localparam logic [3:0] ST_EVICT = 4'd3;
   localparam logic [3:0] ST_PUSH  = 4'd4;
   localparam logic [3:0] ST_HASH  = 4'd5;
   localparam logic [3:0] ST_RECIP = 4'd6;
   localparam logic [3:0] ST_QUOT  = 4'd7;
   localparam logic [3:0] ST_MOD   = 4'd8;
   localparam logic [3:0] ST_PROBE = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   // Control state
   logic [3:0]             state_ff, state_in;
   logic [SLOT_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [WINDOW_W-1:0]    window_ff, window_in;
   logic [PTR_W-1:0]       wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0]       rd_pos_ff, rd_pos_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [47:0]            pkt_cnt_ff, pkt_cnt_in;
   logic [47:0]            byte_cnt_ff, byte_cnt_in;
   logic [4:0][31:0]       flag_cnt_ff, flag_cnt_in;
   logic [1:0][10:0]       distinct_ff, distinct_in;
   logic                   sel_ff, sel_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [63:0]            stamp_ff;
   logic [15:0]            bytes_ff;
   logic [7:0]             flags_ff;
   logic [15:0]            sport_ff;
   logic [15:0]            dport_ff;
   logic [63:0]            cutoff_ff, cutoff_in;
   logic [31:0]            hash_ff, hash_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      probe_ff, probe_in;
   logic [1:0]             new_ff, new_in;
   logic [295:0]           rsp_data_ff;

   // Datapath signals
   logic                   req_accept;
   logic                   rsp_load;
   mul_req_type            mul_req;
   logic [63:0]            mul_q;
   logic [PTR_W-1:0]       rd_pos_inc;
   logic [PTR_W-1:0]       wr_pos_inc;
   logic [PTR_W-1:0]       ring_rd_addr;
   logic                   ring_wr_en;
   logic [63:0]            ring_rd_data;
   logic                   evict_hit;
   logic [15:0]            cur_port;
   logic [SLOT_W-1:0]      set_rd_addr;
   logic [SLOT_W-1:0]      set_wr_addr;
   logic [15:0]            set_wr_data;
   logic                   src_wr_en;
   logic                   dst_wr_en;
   logic [15:0]            src_rd_data;
   logic [15:0]            dst_rd_data;
   logic [15:0]            set_rd_data;
   logic [SLOT_W-1:0]      slot_inc;
   logic [31:0]            mod_diff;
   logic [31:0]            mod_fold;
   logic [SLOT_W-1:0]      mod_slot;
   logic [63:0]            fill_wide;
   logic [31:0]            oldest_calc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign rd_pos_inc  = (rd_pos_ff == PTR_LAST) ? '0 : rd_pos_ff + 1'b1;
   assign wr_pos_inc  = (wr_pos_ff == PTR_LAST) ? '0 : wr_pos_ff + 1'b1;
   assign slot_inc    = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
   assign evict_hit   = (fill_ff != '0) && (ring_rd_data < cutoff_ff);
   assign cur_port    = sel_ff ? dport_ff : sport_ff;
   assign set_rd_data = sel_ff ? dst_rd_data : src_rd_data;

   // Reduce the hash to a slot: quotient estimate is at most one low
   assign mod_diff = hash_ff - mul_q[31:0];
   assign mod_fold = (mod_diff >= SLOT_COUNT) ? mod_diff - SLOT_COUNT : mod_diff;
   assign mod_slot = mod_fold[SLOT_W-1:0];

   // Shared multiplier
   fsws_mul #(
      .PORT_SET_SLOTS(PORT_SET_SLOTS)
   ) u_mul (
      .clock   (clock),
      .req     (mul_req),
      .product (mul_q)
   );

   // Timestamp ring
   fsws_ram #(
      .WIDTH(64),
      .DEPTH(RING_DEPTH)
   ) u_stamp_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (wr_pos_ff),
      .wr_data (stamp_ff),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   // Source port set
   fsws_ram #(
      .WIDTH(16),
      .DEPTH(PORT_SET_SLOTS)
   ) u_src_set (
      .clock   (clock),
      .wr_en   (src_wr_en),
      .wr_addr (set_wr_addr),
      .wr_data (set_wr_data),
      .rd_addr (set_rd_addr),
      .rd_data (src_rd_data)
   );

   // Destination port set
   fsws_ram #(
      .WIDTH(16),
      .DEPTH(PORT_SET_SLOTS)
   ) u_dst_set (
      .clock   (clock),
      .wr_en   (dst_wr_en),
      .wr_addr (set_wr_addr),
      .wr_data (set_wr_data),
      .rd_addr (set_rd_addr),
      .rd_data (dst_rd_data)
   );

   // Sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      window_in    = csr_wr_en ? csr_wr_data : window_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      fill_in      = fill_ff;
      pkt_cnt_in   = pkt_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      flag_cnt_in  = flag_cnt_ff;
      distinct_in  = distinct_ff;
      sel_in       = sel_ff;
      cutoff_in    = cutoff_ff;
      hash_in      = hash_ff;
      slot_in      = slot_ff;
      probe_in     = probe_ff;
      new_in       = new_ff;
      rsp_load     = 1'b0;
      ring_wr_en   = 1'b0;
      ring_rd_addr = rd_pos_ff;
      set_rd_addr  = slot_ff;
      set_wr_addr  = slot_ff;
      set_wr_data  = cur_port;
      src_wr_en    = 1'b0;
      dst_wr_en    = 1'b0;
      mul_req.op      = MUL_SPAN;
      mul_req.operand = 32'(window_ff);

      unique case (state_ff)
         // Empty both port sets, one slot a cycle
         ST_CLEAR: begin
            src_wr_en   = 1'b1;
            dst_wr_en   = 1'b1;
            set_wr_addr = clr_cnt_ff;
            set_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         // Wait for a request; the multiplier forms the window span meanwhile
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CUT;
            end
         end
         // Form the eviction cutoff, or skip eviction
         ST_CUT: begin
            if ((fill_ff == '0) || (stamp_ff == '0)) begin
               state_in = ST_PUSH;
            end else begin
               cutoff_in = (stamp_ff > mul_q) ? stamp_ff - mul_q : '0;
               state_in  = ST_EVICT;
            end
         end
         // Drop the oldest stamp while it is below the cutoff
         ST_EVICT: begin
            if (evict_hit) begin
               fill_in      = fill_ff - 1'b1;
               rd_pos_in    = rd_pos_inc;
               ring_rd_addr = rd_pos_inc;
            end else begin
               state_in = ST_PUSH;
            end
         end
         // Push the stamp and advance the counters
         ST_PUSH: begin
            ring_wr_en = 1'b1;
            wr_pos_in  = wr_pos_inc;
            if (fill_ff != FILL_FULL) begin
               fill_in = fill_ff + 1'b1;
            end else begin
               rd_pos_in = rd_pos_inc;
            end
            pkt_cnt_in  = pkt_cnt_ff + 48'd1;
            byte_cnt_in = byte_cnt_ff + 48'(bytes_ff);
            if (flags_ff[FLAG_SYN]) flag_cnt_in[CNT_SYN] = flag_cnt_ff[CNT_SYN] + 1'b1;
            if (flags_ff[FLAG_ACK]) flag_cnt_in[CNT_ACK] = flag_cnt_ff[CNT_ACK] + 1'b1;
            if (flags_ff[FLAG_FIN]) flag_cnt_in[CNT_FIN] = flag_cnt_ff[CNT_FIN] + 1'b1;
            if (flags_ff[FLAG_RST]) flag_cnt_in[CNT_RST] = flag_cnt_ff[CNT_RST] + 1'b1;
            if (flags_ff[FLAG_PSH]) flag_cnt_in[CNT_PSH] = flag_cnt_ff[CNT_PSH] + 1'b1;
            sel_in   = 1'b0;
            state_in = ST_HASH;
         end
         // Hash the current port, or pass over port zero
         ST_HASH: begin
            if (cur_port == '0) begin
               new_in[sel_ff] = 1'b0;
               sel_in   = 1'b1;
               state_in = sel_ff ? ST_DONE : ST_HASH;
            end else begin
               mul_req.op      = MUL_HASH;
               mul_req.operand = 32'(cur_port);
               state_in        = ST_RECIP;
            end
         end
         // Hold the hash and estimate its quotient by the slot count
         ST_RECIP: begin
            hash_in         = mul_q[31:0];
            mul_req.op      = MUL_RECIP;
            mul_req.operand = mul_q[31:0];
            state_in        = ST_QUOT;
         end
         // Multiply the quotient back by the slot count
         ST_QUOT: begin
            mul_req.op      = MUL_QUOT;
            mul_req.operand = mul_q[63:32];
            state_in        = ST_MOD;
         end
         // Fold the remainder into the home slot and read it
         ST_MOD: begin
            slot_in     = mod_slot;
            set_rd_addr = mod_slot;
            probe_in    = '0;
            state_in    = ST_PROBE;
         end
         // Walk the slots: hit, claim an empty slot, or give up on a full set
         ST_PROBE: begin
            if (set_rd_data == cur_port) begin
               new_in[sel_ff] = 1'b0;
               sel_in   = 1'b1;
               state_in = sel_ff ? ST_DONE : ST_HASH;
            end else if (set_rd_data == '0) begin
               src_wr_en = !sel_ff;
               dst_wr_en = sel_ff;
               new_in[sel_ff]      = 1'b1;
               distinct_in[sel_ff] = distinct_ff[sel_ff] + 1'b1;
               sel_in   = 1'b1;
               state_in = sel_ff ? ST_DONE : ST_HASH;
            end else if (probe_ff == SLOT_LAST) begin
               new_in[sel_ff] = 1'b0;
               sel_in   = 1'b1;
               state_in = sel_ff ? ST_DONE : ST_HASH;
            end else begin
               slot_in     = slot_inc;
               set_rd_addr = slot_inc;
               probe_in    = probe_ff + 1'b1;
            end
         end
         // Hand the snapshot to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output handshake
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         window_ff    <= WINDOW_RESET;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         fill_ff      <= '0;
         pkt_cnt_ff   <= '0;
         byte_cnt_ff  <= '0;
         flag_cnt_ff  <= '0;
         distinct_ff  <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         window_ff    <= window_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         fill_ff      <= fill_in;
         pkt_cnt_ff   <= pkt_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         flag_cnt_ff  <= flag_cnt_in;
         distinct_ff  <= distinct_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign fill_wide = 64'(fill_ff);

   // Working registers and request capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stamp_ff <= req_tdata[63:0];
         bytes_ff <= req_tdata[79:64];
         flags_ff <= req_tdata[87:80];
         sport_ff <= req_tdata[103:88];
         dport_ff <= req_tdata[119:104];
      end
      cutoff_ff <= cutoff_in;
      hash_ff   <= hash_in;
      slot_ff   <= slot_in;
      probe_ff  <= probe_in;
      new_ff    <= new_in;
      if (rsp_load) begin
         rsp_data_ff <= {3'b000, new_ff[1], new_ff[0], distinct_ff[1], distinct_ff[0],
                         flag_cnt_ff[CNT_PSH], flag_cnt_ff[CNT_RST], flag_cnt_ff[CNT_FIN],
                         flag_cnt_ff[CNT_ACK], flag_cnt_ff[CNT_SYN], byte_cnt_ff,
                         pkt_cnt_ff, fill_wide[12:0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Oldest ring position implied by write position and fill
   assign oldest_calc = (32'(wr_pos_ff) >= 32'(fill_ff)) ?
                        32'(wr_pos_ff) - 32'(fill_ff) :
                        32'(wr_pos_ff) + 32'(RING_DEPTH) - 32'(fill_ff);

   // Fill never passes the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("ring fill exceeds depth");

   // Read pointer tracks the oldest held stamp
   a_oldest_track: assert property (@(posedge clock) disable iff (reset)
      oldest_calc == 32'(rd_pos_ff))
      else $error("ring read pointer out of step with fill");

   // A push below full grows the fill by one
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && fill_ff != FILL_FULL) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("push did not grow the ring fill");

   // A new-port mark never comes from port zero
   a_new_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(new_ff[0] && sport_ff == '0) && !(new_ff[1] && dport_ff == '0))
      else $error("port zero marked as newly inserted");

endmodule

`default_nettype wire
